/* hw/rtl/i2a_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

	// operand width and derived digit store sizes
	localparam int VALUE_WIDTH = 32;
	localparam int DEC_DIGITS  = (VALUE_WIDTH * 302) / 1000 + 1;
	localparam int OCT_DIGITS  = (VALUE_WIDTH + 2) / 3;
	localparam int HEX_NIBBLES = (VALUE_WIDTH + 3) / 4;
	localparam int DEC_BITS    = 4 * DEC_DIGITS;
	localparam int OCT_BITS    = 3 * OCT_DIGITS;
	localparam int HEX_BITS    = 4 * HEX_NIBBLES;
	localparam int MAX_A       = (DEC_BITS > VALUE_WIDTH) ? DEC_BITS : VALUE_WIDTH;
	localparam int MAX_B       = (OCT_BITS > HEX_BITS) ? OCT_BITS : HEX_BITS;
	localparam int SHIFT_BITS  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
	localparam int CNT_BITS    = $clog2(VALUE_WIDTH + 1);

	// conversion kinds
	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_OCT  = 3'd2;
	localparam logic [2:0] KIND_HEX  = 3'd3;
	localparam logic [2:0] KIND_BIN  = 3'd4;

	// flag bit positions
	localparam int FLAG_PLUS_BIT  = 0;
	localparam int FLAG_SPACE_BIT = 1;
	localparam int FLAG_ALT_BIT   = 2;

	// ascii codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_B_LO  = 8'h62;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [2:0]             kind;
		logic                   uppercase;
		logic [2:0]             flags;
	} i2a_in_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} i2a_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PRE,
		ST_SKIP,
		ST_EMIT
	} i2a_state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] ch;
		if (d < 4'd10) begin
			ch = CH_ZERO + {4'd0, d};
		end else begin
			ch = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps
// sequence: decimal kinds first run the bit-serial double-dabble bcd loop; then the sign or
// prefix characters are emitted, leading zeros are skipped in the digit shifter and the digits
// are emitted, each character waiting for a free output register; a new value is taken only
// after the last digit of the previous one has been emitted
// reset: arst_n clears the sequencer and the output valid; the block then takes a value at once
`default_nettype none
module integer_to_ascii_formatter_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire i2a_pkg::i2a_in_t in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output i2a_pkg::i2a_out_t  out_data
);
	import i2a_pkg::*;

	// sequencer and counters
	i2a_state_t            state_q, state_d;
	logic [CNT_BITS-1:0]   cnt_q, cnt_d;
	logic [1:0]            pre_cnt_q, pre_cnt_d;
	logic                  out_valid_q, out_valid_d;

	// payload registers
	logic [SHIFT_BITS-1:0]  dig_q, dig_d;
	logic [VALUE_WIDTH-1:0] src_q, src_d;
	logic [DEC_BITS-1:0]    bcd_q, bcd_d, bcd_adj;
	logic [2:0]             kind_q, kind_d;
	logic                   upper_q, upper_d;
	logic [7:0]             pre0_q, pre0_d, pre1_q, pre1_d;
	i2a_out_t               out_q, out_d;

	// load-time decode of the incoming transaction
	logic [2:0]             kind_n;
	logic                   is_dec_n;
	logic                   neg_n;
	logic                   nonzero_n;
	logic [VALUE_WIDTH-1:0] mag_n;

	// digit at the top of the shifter and the shifter advanced by one digit
	logic [3:0]            top_digit;
	logic [SHIFT_BITS-1:0] dig_shift;

	logic in_fire;
	logic slot_free;
	logic emit;
	logic [7:0] emit_char;
	logic emit_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	// output register frees up when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		kind_n    = (in_data.kind > KIND_BIN) ? KIND_UDEC : in_data.kind;
		is_dec_n  = (kind_n == KIND_SDEC) || (kind_n == KIND_UDEC);
		neg_n     = (kind_n == KIND_SDEC) && in_data.value[VALUE_WIDTH-1];
		nonzero_n = (in_data.value != '0);
		mag_n     = neg_n ? (~in_data.value + 1'b1) : in_data.value;
	end

	// shift-add-3 correction on every bcd digit, independent lanes
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// digit size follows the kind: 1 bit binary, 3 octal, 4 hex and bcd
	always_comb begin
		case (kind_q)
			KIND_BIN: begin
				top_digit = {3'd0, dig_q[SHIFT_BITS-1]};
				dig_shift = {dig_q[SHIFT_BITS-2:0], 1'b0};
			end
			KIND_OCT: begin
				top_digit = {1'b0, dig_q[SHIFT_BITS-1 -: 3]};
				dig_shift = {dig_q[SHIFT_BITS-4:0], 3'd0};
			end
			default: begin
				top_digit = dig_q[SHIFT_BITS-1 -: 4];
				dig_shift = {dig_q[SHIFT_BITS-5:0], 4'd0};
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pre_cnt_d = pre_cnt_q;
		dig_d     = dig_q;
		src_d     = src_q;
		bcd_d     = bcd_q;
		kind_d    = kind_q;
		upper_d   = upper_q;
		pre0_d    = pre0_q;
		pre1_d    = pre1_q;
		emit      = 1'b0;
		emit_char = digit_char(top_digit, upper_q);
		emit_last = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					kind_d    = kind_n;
					upper_d   = in_data.uppercase;
					pre_cnt_d = 2'd0;
					pre0_d    = CH_ZERO;
					pre1_d    = CH_ZERO;
					// sign for signed decimal, prefix for the other bases
					if (kind_n == KIND_SDEC) begin
						if (neg_n) begin
							pre_cnt_d = 2'd1;
							pre0_d    = CH_MINUS;
						end else if (in_data.flags[FLAG_PLUS_BIT]) begin
							pre_cnt_d = 2'd1;
							pre0_d    = CH_PLUS;
						end else if (in_data.flags[FLAG_SPACE_BIT]) begin
							pre_cnt_d = 2'd1;
							pre0_d    = CH_SPACE;
						end
					end else if (in_data.flags[FLAG_ALT_BIT] && nonzero_n) begin
						case (kind_n)
							KIND_OCT: begin
								pre_cnt_d = 2'd1;
							end
							KIND_HEX: begin
								pre_cnt_d = 2'd2;
								pre1_d    = in_data.uppercase ? CH_X_UP : CH_X_LO;
							end
							KIND_BIN: begin
								pre_cnt_d = 2'd2;
								pre1_d    = CH_B_LO;
							end
							default: begin
								pre_cnt_d = 2'd0;
							end
						endcase
					end
					// decimal goes through the bcd loop, other bases load left-aligned
					dig_d = '0;
					src_d = mag_n;
					bcd_d = '0;
					if (is_dec_n) begin
						cnt_d   = CNT_BITS'(VALUE_WIDTH);
						state_d = ST_CONV;
					end else begin
						case (kind_n)
							KIND_OCT: begin
								dig_d[SHIFT_BITS-1 -: OCT_BITS] = OCT_BITS'(in_data.value);
								cnt_d = CNT_BITS'(OCT_DIGITS);
							end
							KIND_HEX: begin
								dig_d[SHIFT_BITS-1 -: HEX_BITS] = HEX_BITS'(in_data.value);
								cnt_d = CNT_BITS'(HEX_NIBBLES);
							end
							default: begin
								dig_d[SHIFT_BITS-1 -: VALUE_WIDTH] = in_data.value;
								cnt_d = CNT_BITS'(VALUE_WIDTH);
							end
						endcase
						state_d = ST_PRE;
					end
				end
			end
			ST_CONV: begin
				bcd_d = {bcd_adj[DEC_BITS-2:0], src_q[VALUE_WIDTH-1]};
				src_d = {src_q[VALUE_WIDTH-2:0], 1'b0};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					dig_d = '0;
					dig_d[SHIFT_BITS-1 -: DEC_BITS] = {bcd_adj[DEC_BITS-2:0], src_q[VALUE_WIDTH-1]};
					cnt_d   = CNT_BITS'(DEC_DIGITS);
					state_d = ST_PRE;
				end
			end
			ST_PRE: begin
				if (pre_cnt_q == 2'd0) begin
					state_d = ST_SKIP;
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_char = pre0_q;
					pre0_d    = pre1_q;
					pre_cnt_d = pre_cnt_q - 1'b1;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keeping at least one digit
				if ((top_digit == 4'd0) && (cnt_q != CNT_BITS'(1))) begin
					dig_d = dig_shift;
					cnt_d = cnt_q - 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_last = (cnt_q == CNT_BITS'(1));
					dig_d     = dig_shift;
					cnt_d     = cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_comb begin
		out_valid_d = out_valid_q;
		out_d       = out_q;
		if (emit) begin
			out_valid_d     = 1'b1;
			out_d.char_code = emit_char;
			out_d.last      = emit_last;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pre_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			pre_cnt_q   <= pre_cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		dig_q   <= dig_d;
		src_q   <= src_d;
		bcd_q   <= bcd_d;
		kind_q  <= kind_d;
		upper_q <= upper_d;
		pre0_q  <= pre0_d;
		pre1_q  <= pre1_d;
		out_q   <= out_d;
	end

	// a transaction in flight blocks the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken twice in a row");

	// a pending character that is not the last one means the value is still in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> !in_ready)
		else $error("idle while a value's text is unfinished");

	// the digit counter never runs dry while busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q != '0))
		else $error("digit counter empty while busy");

	// a character is only produced when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("pending character overwritten");

endmodule
`default_nettype wire
